FILE: design/lrgd_pkg.sv
// Shared types, codes and constants for the linear regression trainer.
`timescale 1ns / 1ps
package lrgd_pkg;

   localparam int MAX_POINTS_DEF = 1024;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int RATE_BITS      = 16;
   localparam int GRAD_BITS      = 48;

   localparam logic [15:0] MAX_ITER_RST  = 16'd30000;
   localparam logic [15:0] LRATE_RST     = 16'd655;
   localparam logic [31:0] THRESH_RST    = 32'd4295;
   localparam logic [15:0] DECAY_RST     = 16'd62259;
   localparam logic [15:0] INTERVAL_RST  = 16'd1000;

   localparam logic [2:0] CSR_MAX_ITER = 3'd0;
   localparam logic [2:0] CSR_LRATE    = 3'd1;
   localparam logic [2:0] CSR_THRESH   = 3'd2;
   localparam logic [2:0] CSR_DECAY    = 3'd3;
   localparam logic [2:0] CSR_INTERVAL = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FEW  = 2'd1;
   localparam logic [1:0] ST_OVER = 2'd2;

   typedef logic [3:0] op_type;

   localparam op_type OP_IDLE     = 4'd0;
   localparam op_type OP_LOAD     = 4'd1;
   localparam op_type OP_START    = 4'd2;
   localparam op_type OP_CLEAR    = 4'd3;
   localparam op_type OP_READ     = 4'd4;
   localparam op_type OP_MUL_WX   = 4'd5;
   localparam op_type OP_ERROR    = 4'd6;
   localparam op_type OP_MUL_EE   = 4'd7;
   localparam op_type OP_MUL_EX   = 4'd8;
   localparam op_type OP_ACCUM    = 4'd9;
   localparam op_type OP_DIV_LOSS = 4'd10;
   localparam op_type OP_DIV_ERR  = 4'd11;
   localparam op_type OP_DIV_ERRX = 4'd12;
   localparam op_type OP_UPD_MUL  = 4'd13;
   localparam op_type OP_UPDATE   = 4'd14;
   localparam op_type OP_RESULT   = 4'd15;

   typedef struct packed {
      op_type     op;
      logic       conv;
      logic [1:0] code;
   } cmd_type;

   typedef struct packed {
      logic pass_last;
      logic div_done;
      logic loss_below;
      logic iter_at_max;
      logic overflow;
      logic few;
      logic rsp_free;
   } stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         sat32 = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

FILE: design/lrgd_divider.sv
// Restoring serial divider, one quotient bit per cycle, for 64 bit dividends.
`timescale 1ns / 1ps
module lrgd_divider #(
   parameter int DW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [63:0]   quotient
);
   logic          busy_ff;
   logic [5:0]    cnt_ff;
   logic          done_ff;
   logic [63:0]   quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] dsr_ff;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   assign trial = {rem_ff, quo_ff[63]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 6'd63);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[62:0], ge};
         rem_ff <= ge ? diff[DW-1:0] : trial[DW-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: design/lrgd_datapath.sv
// Datapath: point memories, shared multiplier, accumulators, divider and updates.
`timescale 1ns / 1ps
module lrgd_datapath #(
   parameter int MAX_POINTS = lrgd_pkg::MAX_POINTS_DEF,
   parameter int FRAC_BITS  = lrgd_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_write_data,
   input  logic signed [31:0]  req_x_value,
   input  logic signed [31:0]  req_y_value,
   input  lrgd_pkg::cmd_type   cmd,
   output lrgd_pkg::stat_type  stat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_slope,
   output logic signed [31:0]  rsp_intercept,
   output logic [15:0]         rsp_iterations_run,
   output logic                rsp_converged,
   output logic [1:0]          rsp_status
);
   import lrgd_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int DW = CW + 1;
   localparam logic [63:0] GRAD_MAX = (64'd1 << (GRAD_BITS - 1)) - 64'd1;
   localparam logic [63:0] GRAD_MIN_MAG = 64'd1 << (GRAD_BITS - 1);

   logic [15:0] max_iter_ff, lrate_ff, decay_ff, interval_ff;
   logic [31:0] thresh_ff;

   logic signed [31:0] x_mem [MAX_POINTS];
   logic signed [31:0] y_mem [MAX_POINTS];
   logic signed [31:0] x_rd_ff, y_rd_ff;
   logic [CW-1:0]      count_ff;
   logic               ovf_ff;
   logic [AW-1:0]      idx_ff;
   logic               room;

   logic signed [31:0] w_ff, b_ff, e_ff;
   logic [15:0]        rate_ff, iter_ff, dcnt_ff;
   logic signed [31:0] ma, mb;
   logic signed [63:0] prod_in, prod_ff;
   logic signed [65:0] pred_err;
   logic [64:0]        sq_sum;
   logic [63:0]        sq_ff;
   logic signed [63:0] se_ff, sex_ff, ex_sh;
   logic signed [64:0] sex_sum;
   logic [63:0]        loss_ff;
   logic signed [31:0] me_ff;
   logic signed [GRAD_BITS-1:0] mex_ff;
   logic signed [48:0] pb_ff;
   logic signed [64:0] pw_ff;
   logic signed [33:0] b_new;
   logic signed [49:0] w_new;
   logic [31:0]        decay_prod;
   logic               decay_now;
   logic [15:0]        dcnt_next;

   logic               div_start, div_done;
   logic [63:0]        div_dividend, div_q, q_neg;
   logic [DW-1:0]      div_divisor;
   logic [1:0]         sel_ff;
   logic               neg_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] slope_ff, icpt_ff;
   logic [15:0]        iters_ff;
   logic               conv_ff;
   logic [1:0]         status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RST;
         lrate_ff    <= LRATE_RST;
         thresh_ff   <= THRESH_RST;
         decay_ff    <= DECAY_RST;
         interval_ff <= INTERVAL_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_ITER: max_iter_ff <= csr_write_data[15:0];
            CSR_LRATE:    lrate_ff    <= csr_write_data[15:0];
            CSR_THRESH:   thresh_ff   <= csr_write_data;
            CSR_DECAY:    decay_ff    <= csr_write_data[15:0];
            CSR_INTERVAL: interval_ff <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign room = count_ff < CW'(MAX_POINTS);

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && room) begin
         x_mem[count_ff[AW-1:0]] <= req_x_value;
         y_mem[count_ff[AW-1:0]] <= req_y_value;
      end
      if (cmd.op == OP_READ) begin
         x_rd_ff <= x_mem[idx_ff];
         y_rd_ff <= y_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.op == OP_LOAD) begin
         if (room) begin
            count_ff <= count_ff + CW'(1);
         end else begin
            ovf_ff <= 1'b1;
         end
      end else if (cmd.op == OP_RESULT) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end
   end

   always_comb begin
      case (cmd.op)
         OP_MUL_WX: begin
            ma = w_ff;
            mb = x_rd_ff;
         end
         OP_MUL_EE: begin
            ma = e_ff;
            mb = e_ff;
         end
         default: begin
            ma = e_ff;
            mb = x_rd_ff;
         end
      endcase
   end

   assign prod_in  = ma * mb;
   assign pred_err = 66'(prod_ff >>> FRAC_BITS) + 66'(b_ff) - 66'(y_rd_ff);
   assign sq_sum   = {1'b0, sq_ff} + {1'b0, prod_ff};
   assign ex_sh    = prod_ff >>> FRAC_BITS;
   assign sex_sum  = 65'(sex_ff) + 65'(ex_sh);

   always_ff @(posedge clock) begin
      if (cmd.op == OP_MUL_WX || cmd.op == OP_MUL_EE || cmd.op == OP_MUL_EX) begin
         prod_ff <= prod_in;
      end
      if (cmd.op == OP_ERROR) begin
         e_ff <= sat32(pred_err);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         sq_ff  <= '0;
         se_ff  <= '0;
         sex_ff <= '0;
      end else if (cmd.op == OP_START || cmd.op == OP_CLEAR) begin
         idx_ff <= '0;
         sq_ff  <= '0;
         se_ff  <= '0;
         sex_ff <= '0;
      end else if (cmd.op == OP_MUL_EX) begin
         sq_ff <= sq_sum[64] ? '1 : sq_sum[63:0];
      end else if (cmd.op == OP_ACCUM) begin
         idx_ff <= idx_ff + AW'(1);
         se_ff  <= se_ff + 64'(e_ff);
         if (sex_sum[64] != sex_sum[63]) begin
            sex_ff <= sex_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         end else begin
            sex_ff <= sex_sum[63:0];
         end
      end
   end

   assign div_start = cmd.op == OP_DIV_LOSS || cmd.op == OP_DIV_ERR ||
                      cmd.op == OP_DIV_ERRX;

   always_comb begin
      case (cmd.op)
         OP_DIV_LOSS: begin
            div_dividend = sq_ff;
            div_divisor  = {count_ff, 1'b0};
         end
         OP_DIV_ERR: begin
            div_dividend = se_ff[63] ? 64'(-se_ff) : 64'(se_ff);
            div_divisor  = {1'b0, count_ff};
         end
         default: begin
            div_dividend = sex_ff[63] ? 64'(-sex_ff) : 64'(sex_ff);
            div_divisor  = {1'b0, count_ff};
         end
      endcase
   end

   lrgd_divider #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign q_neg = -div_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         loss_ff <= '0;
      end else if (div_done && sel_ff == 2'd0) begin
         loss_ff <= div_q;
      end
      if (div_start) begin
         sel_ff <= cmd.op == OP_DIV_LOSS ? 2'd0 : (cmd.op == OP_DIV_ERR ? 2'd1 : 2'd2);
         neg_ff <= cmd.op == OP_DIV_ERR ? se_ff[63] : sex_ff[63];
      end
      if (div_done && sel_ff == 2'd1) begin
         me_ff <= neg_ff ? q_neg[31:0] : div_q[31:0];
      end
      if (div_done && sel_ff == 2'd2) begin
         if (!neg_ff) begin
            mex_ff <= (div_q > GRAD_MAX) ? GRAD_MAX[GRAD_BITS-1:0] : div_q[GRAD_BITS-1:0];
         end else begin
            mex_ff <= (div_q > GRAD_MIN_MAG) ? q_neg[GRAD_BITS-1:0] & '0 |
                      GRAD_MIN_MAG[GRAD_BITS-1:0] : q_neg[GRAD_BITS-1:0];
         end
      end
   end

   assign b_new      = 34'(b_ff) - 34'(pb_ff >>> RATE_BITS);
   assign w_new      = 50'(w_ff) - 50'(pw_ff >>> RATE_BITS);
   assign decay_prod = rate_ff * decay_ff;
   assign decay_now  = iter_ff != 16'd0 && interval_ff != 16'd0 && dcnt_ff == 16'd0;
   assign dcnt_next  = (dcnt_ff + 16'd1 == interval_ff) ? 16'd0 : dcnt_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (cmd.op == OP_UPD_MUL) begin
         pb_ff <= $signed({1'b0, rate_ff}) * me_ff;
         pw_ff <= $signed({1'b0, rate_ff}) * mex_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= '0;
         b_ff    <= '0;
         rate_ff <= LRATE_RST;
         iter_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.op == OP_START) begin
         w_ff    <= '0;
         b_ff    <= '0;
         rate_ff <= lrate_ff;
         iter_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.op == OP_UPDATE) begin
         b_ff    <= sat32(66'(b_new));
         w_ff    <= sat32(66'(w_new));
         iter_ff <= iter_ff + 16'd1;
         dcnt_ff <= dcnt_next;
         if (decay_now) begin
            rate_ff <= decay_prod[31:16];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_RESULT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_RESULT) begin
         slope_ff  <= (cmd.code == ST_OK) ? w_ff : '0;
         icpt_ff   <= (cmd.code == ST_OK) ? b_ff : '0;
         iters_ff  <= (cmd.code == ST_OK) ? iter_ff : '0;
         conv_ff   <= cmd.conv;
         status_ff <= cmd.code;
      end
   end

   assign stat.pass_last   = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign stat.div_done    = div_done;
   assign stat.loss_below  = loss_ff < 64'(thresh_ff);
   assign stat.iter_at_max = iter_ff == max_iter_ff;
   assign stat.overflow    = ovf_ff;
   assign stat.few         = count_ff < CW'(2);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slope          = slope_ff;
   assign rsp_intercept      = icpt_ff;
   assign rsp_iterations_run = iters_ff;
   assign rsp_converged      = conv_ff;
   assign rsp_status         = status_ff;
endmodule

FILE: design/lrgd_controller.sv
// Controller state machine that sequences loading, passes, divisions and updates.
`timescale 1ns / 1ps
module lrgd_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_last_point,
   input  lrgd_pkg::stat_type stat,
   output lrgd_pkg::cmd_type  cmd
);
   import lrgd_pkg::*;

   localparam logic [4:0] S_LOAD  = 5'd0;
   localparam logic [4:0] S_SETUP = 5'd1;
   localparam logic [4:0] S_READ  = 5'd2;
   localparam logic [4:0] S_MWX   = 5'd3;
   localparam logic [4:0] S_ERR   = 5'd4;
   localparam logic [4:0] S_MEE   = 5'd5;
   localparam logic [4:0] S_MEX   = 5'd6;
   localparam logic [4:0] S_ACC   = 5'd7;
   localparam logic [4:0] S_DLOSS = 5'd8;
   localparam logic [4:0] S_WLOSS = 5'd9;
   localparam logic [4:0] S_DERR  = 5'd10;
   localparam logic [4:0] S_WERR  = 5'd11;
   localparam logic [4:0] S_DERRX = 5'd12;
   localparam logic [4:0] S_WERRX = 5'd13;
   localparam logic [4:0] S_UMUL  = 5'd14;
   localparam logic [4:0] S_UPD   = 5'd15;
   localparam logic [4:0] S_CHECK = 5'd16;
   localparam logic [4:0] S_OUT   = 5'd17;

   logic [4:0] state_ff, state_in;
   logic       first_ff, first_in;
   logic       conv_ff, conv_in;
   logic [1:0] code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      first_in = first_ff;
      conv_in  = conv_ff;
      code_in  = code_ff;
      cmd.op   = OP_IDLE;
      cmd.conv = conv_ff;
      cmd.code = code_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (req_last_point) begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            conv_in = 1'b0;
            if (stat.overflow) begin
               code_in  = ST_OVER;
               state_in = S_OUT;
            end else if (stat.few) begin
               code_in  = ST_FEW;
               state_in = S_OUT;
            end else begin
               cmd.op   = OP_START;
               code_in  = ST_OK;
               first_in = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.op   = OP_READ;
            state_in = S_MWX;
         end
         S_MWX: begin
            cmd.op   = OP_MUL_WX;
            state_in = S_ERR;
         end
         S_ERR: begin
            cmd.op   = OP_ERROR;
            state_in = S_MEE;
         end
         S_MEE: begin
            cmd.op   = OP_MUL_EE;
            state_in = S_MEX;
         end
         S_MEX: begin
            cmd.op   = OP_MUL_EX;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op   = OP_ACCUM;
            state_in = stat.pass_last ? S_DLOSS : S_READ;
         end
         S_DLOSS: begin
            cmd.op   = OP_DIV_LOSS;
            state_in = S_WLOSS;
         end
         S_WLOSS: begin
            if (stat.div_done) begin
               state_in = S_DERR;
            end
         end
         S_DERR: begin
            cmd.op   = OP_DIV_ERR;
            state_in = S_WERR;
         end
         S_WERR: begin
            if (stat.div_done) begin
               state_in = S_DERRX;
            end
         end
         S_DERRX: begin
            cmd.op   = OP_DIV_ERRX;
            state_in = S_WERRX;
         end
         S_WERRX: begin
            if (stat.div_done) begin
               first_in = 1'b0;
               state_in = first_ff ? S_CHECK : S_UMUL;
            end
         end
         S_UMUL: begin
            cmd.op   = OP_UPD_MUL;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.op   = OP_UPDATE;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.iter_at_max) begin
               state_in = S_OUT;
            end else if (stat.loss_below) begin
               conv_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.op   = OP_CLEAR;
               state_in = S_READ;
            end
         end
         S_OUT: begin
            if (stat.rsp_free) begin
               cmd.op   = OP_RESULT;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         first_ff <= 1'b0;
         conv_ff  <= 1'b0;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         conv_ff  <= conv_in;
         code_ff  <= code_in;
      end
   end

   assign req_ready = state_ff == S_LOAD;
endmodule

FILE: design/linear_regression_gradient_descent_top.sv
// Top level of the linear regression trainer: controller plus datapath.
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_ready     x_value, y_value, last_point
//   rsp       out        rsp_valid / rsp_ready     slope, intercept, iterations_run,
//                                                  converged, status
//   csr       in         csr_write_enable          csr_index, csr_write_data
//
// Points are taken one beat per cycle while the block is loading.
// After the last point, each training pass steps every stored point through the
// shared multiplier sequence, then runs the three
// 64 step serial divisions and the update and check; an initial pass
// runs first. Input beats are held off during training.
// Reset is synchronous; the point memories need no clearing pass.
// A result waits in the output register while a new data set loads.
`timescale 1ns / 1ps
module linear_regression_gradient_descent_top #(
   parameter int MAX_POINTS = lrgd_pkg::MAX_POINTS_DEF,
   parameter int FRAC_BITS  = lrgd_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_slope,
   output logic signed [31:0] rsp_intercept,
   output logic [15:0]        rsp_iterations_run,
   output logic               rsp_converged,
   output logic [1:0]         rsp_status
);
   import lrgd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lrgd_controller u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_last_point (req_last_point),
      .stat           (stat),
      .cmd            (cmd)
   );

   lrgd_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_x_value        (req_x_value),
      .req_y_value        (req_y_value),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_slope          (rsp_slope),
      .rsp_intercept      (rsp_intercept),
      .rsp_iterations_run (rsp_iterations_run),
      .rsp_converged      (rsp_converged),
      .rsp_status         (rsp_status)
   );
endmodule

FILE: design/lrgd_checker.sv
// Port level checks for the linear regression trainer, bound to the top level.
`timescale 1ns / 1ps
module lrgd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_last_point,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_slope,
   input logic signed [31:0] rsp_intercept,
   input logic [15:0]        rsp_iterations_run,
   input logic               rsp_converged,
   input logic [1:0]         rsp_status
);
   import lrgd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slope) &&
      $stable(rsp_intercept) && $stable(rsp_status))
      else $error("stalled result beat changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_slope == 0 && rsp_intercept == 0 &&
      rsp_iterations_run == 16'd0 && !rsp_converged)
      else $error("error result carries a fit");

   a_conv_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_converged |-> rsp_status == ST_OK)
      else $error("converged flag on an error result");

   a_last_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_point |=> !req_ready)
      else $error("input taken right after the last point");
endmodule

bind linear_regression_gradient_descent_top lrgd_checker u_lrgd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_last_point     (req_last_point),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_slope          (rsp_slope),
   .rsp_intercept      (rsp_intercept),
   .rsp_iterations_run (rsp_iterations_run),
   .rsp_converged      (rsp_converged),
   .rsp_status         (rsp_status)
);

FILE: tb/linear_regression_gradient_descent_top_tb.sv
// Self-checking testbench for the linear regression trainer top level.
`timescale 1ns / 1ps
module linear_regression_gradient_descent_top_tb;
   import lrgd_pkg::*;

   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
      logic [15:0]        iters;
      logic               conv;
      logic [1:0]         status;
   } fit_type;

   typedef struct {
      int                 cfg_iters;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               last;
      bit                 typed;
      fit_type            fit;
   } row_type;

   logic clock, reset;
   logic csr_write_enable;
   logic [2:0] csr_index;
   logic [31:0] csr_write_data;
   logic req_valid, req_ready;
   logic signed [31:0] req_x_value, req_y_value;
   logic req_last_point;
   logic rsp_valid, rsp_ready;
   logic signed [31:0] rsp_slope, rsp_intercept;
   logic [15:0] rsp_iterations_run;
   logic rsp_converged;
   logic [1:0] rsp_status;

   linear_regression_gradient_descent_top dut (.*);

   logic [15:0] max_iter_q = MAX_ITER_RST;
   logic [15:0] lrate_q    = LRATE_RST;
   logic [31:0] thresh_q   = THRESH_RST;
   logic [15:0] decay_q    = DECAY_RST;
   logic [15:0] interval_q = INTERVAL_RST;

   logic signed [31:0] set_x[MAX_POINTS_DEF];
   logic signed [31:0] set_y[MAX_POINTS_DEF];
   int      set_count;
   bit      set_overflow;
   fit_type pending_fits[$];
   int      failures;
   int      beats;
   bit      ignore_typed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic signed [31:0] clip32(input logic signed [79:0] v);
      if (v > 80'sd2147483647) return 32'sh7fffffff;
      if (v < -80'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic void scan_points(input int n, input logic signed [31:0] w,
                                       input logic signed [31:0] b,
                                       output logic [63:0] loss,
                                       output logic signed [63:0] me,
                                       output logic signed [63:0] mex);
      logic [64:0] sq;
      logic signed [63:0] se, x, p, e, q;
      logic signed [65:0] sex;
      logic signed [63:0] w64, b64;
      sq = 0;
      se = 0;
      sex = 0;
      w64 = w;
      b64 = b;
      for (int j = 0; j < n; j++) begin
         x = set_x[j];
         p = ((w64 * x) >>> FRAC_BITS_DEF) + b64;
         e = p - 64'(set_y[j]);
         if (e > 64'sd2147483647) e = 64'sd2147483647;
         if (e < -64'sd2147483648) e = -64'sd2147483648;
         sq = sq + 65'(e * e);
         if (sq[64]) sq = {1'b0, 64'hffffffffffffffff};
         se = se + e;
         sex = sex + 66'((e * x) >>> FRAC_BITS_DEF);
         if (sex > 66'sh0_7fffffffffffffff) sex = 66'sh0_7fffffffffffffff;
         if (sex < -66'sh0_8000000000000000) sex = -66'sh0_8000000000000000;
      end
      me = se / 64'(n);
      q = 64'(sex) / 64'(n);
      if (q > 64'sd140737488355327) q = 64'sd140737488355327;
      if (q < -64'sd140737488355328) q = -64'sd140737488355328;
      mex = q;
      loss = sq[63:0] / (64'(n) * 2);
   endfunction

   function automatic fit_type fit_line();
      fit_type f;
      logic [63:0] loss;
      logic signed [63:0] me, mex;
      logic [15:0] rate;
      logic signed [79:0] t;
      f = '{0, 0, 0, 0, ST_OK};
      if (set_overflow) begin
         f.status = ST_OVER;
      end else if (set_count < 2) begin
         f.status = ST_FEW;
      end else begin
         rate = lrate_q;
         scan_points(set_count, f.slope, f.intercept, loss, me, mex);
         for (int i = 0; i < int'(max_iter_q); i++) begin
            if (loss < 64'(thresh_q)) begin
               f.conv = 1'b1;
               break;
            end
            scan_points(set_count, f.slope, f.intercept, loss, me, mex);
            t = $signed({1'b0, rate}) * me;
            f.intercept = clip32(80'(f.intercept) - (t >>> RATE_BITS));
            t = $signed({1'b0, rate}) * mex;
            f.slope = clip32(80'(f.slope) - (t >>> RATE_BITS));
            f.iters++;
            if (i > 0 && interval_q != 0 && (i % int'(interval_q)) == 0)
               rate = 16'((32'(rate) * 32'(decay_q)) >> RATE_BITS);
         end
      end
      return f;
   endfunction

   task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic last, input bit typed, input fit_type typed_fit);
      int gap;
      fit_type f;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_x_value = x;
      req_y_value = y;
      req_last_point = last;
      do @(posedge clock); while (!req_ready);
      beats++;
      if (set_count < MAX_POINTS_DEF) begin
         set_x[set_count] = x;
         set_y[set_count] = y;
         set_count++;
      end else begin
         set_overflow = 1'b1;
      end
      if (last) begin
         f = fit_line();
         if (typed && !ignore_typed && f != typed_fit) begin
            $error("typed row disagrees with predictor");
            failures++;
         end
         pending_fits.push_back(f);
         set_count = 0;
         set_overflow = 1'b0;
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_fits.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      case (idx)
         CSR_MAX_ITER: max_iter_q = data[15:0];
         CSR_LRATE:    lrate_q = data[15:0];
         CSR_THRESH:   thresh_q = data;
         CSR_DECAY:    decay_q = data[15:0];
         CSR_INTERVAL: interval_q = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic signed [31:0] pick_value(input bit tame);
      if (tame) return $signed(32'($urandom_range(0, 512))) - 256;
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 0;
         3, 4: return $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
         default: return $signed($urandom);
      endcase
   endfunction

   initial begin
      fit_type none;
      row_type rows[$];
      fit_type ok_zero;
      int n;
      bit tame;
      none = '{0, 0, 0, 0, ST_OK};
      ok_zero = '{0, 0, 0, 0, ST_OK};
      rows = '{
         '{-1, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 1, '{0, 0, 0, 0, ST_FEW}},
         '{-1, 32'sh7fffffff, 0, 1'b0, 0, none},
         '{-1, 32'sh80000000, 0, 1'b1, 1, '{0, 0, 0, 1, ST_OK}},
         '{0, 32'sh7fffffff, 32'sh80000000, 1'b0, 0, none},
         '{-1, 32'sh80000000, 32'sh7fffffff, 1'b1, 1, ok_zero},
         '{12, 32'sh00010000, 32'sh00020000, 1'b0, 0, none},
         '{-1, 32'sh00020000, 32'sh00040000, 1'b0, 0, none},
         '{-1, 32'sh00030000, 32'sh00060000, 1'b1, 0, none},
         '{-1, 32'sh7fffffff, 32'sh80000000, 1'b0, 0, none},
         '{-1, 32'sh80000000, 32'sh7fffffff, 1'b0, 0, none},
         '{-1, 32'sh80000000, 32'sh80000000, 1'b1, 0, none},
         '{-1, 32'shffff0000, 32'sh7fffffff, 1'b0, 0, none},
         '{-1, 32'sh00000001, 32'shffffffff, 1'b1, 0, none},
         '{-1, 32'sh00005555, 32'shaaaaaaaa, 1'b1, 1, '{0, 0, 0, 0, ST_FEW}}
      };
      failures = 0;
      beats = 0;
      set_count = 0;
      set_overflow = 1'b0;
      ignore_typed = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_MAX_ITER;
      csr_write_data = 0;
      req_valid = 1'b0;
      req_x_value = 0;
      req_y_value = 0;
      req_last_point = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[k]) begin
         if (rows[k].cfg_iters >= 0) begin
            drain();
            write_csr(CSR_MAX_ITER, rows[k].cfg_iters);
         end
         send_point(rows[k].x, rows[k].y, rows[k].last, rows[k].typed, rows[k].fit);
      end

      for (int phase = 0; phase < 10; phase++) begin
         drain();
         tame = 1'b0;
         case (phase)
            0: begin
               write_csr(CSR_MAX_ITER, 32'h0000ffff);
               write_csr(CSR_THRESH, 32'hffffffff);
               tame = 1'b1;
            end
            1: begin
               write_csr(CSR_MAX_ITER, 8);
               write_csr(CSR_LRATE, 32'h0000ffff);
               write_csr(CSR_THRESH, 0);
               write_csr(CSR_DECAY, 0);
               write_csr(CSR_INTERVAL, 1);
            end
            2: begin
               write_csr(CSR_LRATE, 0);
               write_csr(CSR_DECAY, 32'h0000ffff);
               write_csr(CSR_INTERVAL, 32'h0000ffff);
            end
            3: write_csr(CSR_INTERVAL, 0);
            default: begin
               write_csr(CSR_MAX_ITER, $urandom_range(0, 12));
               write_csr(CSR_LRATE, $urandom_range(0, 16'hffff));
               write_csr(CSR_THRESH, ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 5000));
               write_csr(CSR_DECAY, $urandom_range(0, 16'hffff));
               write_csr(CSR_INTERVAL, $urandom_range(1, 4));
            end
         endcase
         if (phase == 5) begin
            for (int k = 0; k < MAX_POINTS_DEF + 3; k++)
               send_point($signed($urandom), $signed($urandom), k == MAX_POINTS_DEF + 2, 0, none);
         end
         for (int s = 0; s < 3; s++) begin
            case ($urandom_range(0, 9))
               0: n = 1;
               1: n = $urandom_range(9, 40);
               default: n = $urandom_range(2, 8);
            endcase
            for (int k = 0; k < n; k++)
               send_point(pick_value(1'b0), pick_value(tame), k == n - 1, 0, none);
         end
      end
      while (beats < 1250) begin
         n = $urandom_range(2, 8);
         for (int k = 0; k < n; k++)
            send_point(pick_value(1'b0), pick_value(1'b0), k == n - 1, 0, none);
      end
      req_valid = 1'b0;
      while (pending_fits.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      fit_type f;
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
         if (pending_fits.size() == 0) begin
            $error("result beat with no fit pending");
            failures++;
         end else begin
            f = pending_fits.pop_front();
            if (rsp_slope !== f.slope) begin
               $error("slope expected %0d actual %0d", f.slope, rsp_slope);
               failures++;
            end
            if (rsp_intercept !== f.intercept) begin
               $error("intercept expected %0d actual %0d", f.intercept, rsp_intercept);
               failures++;
            end
            if (rsp_iterations_run !== f.iters) begin
               $error("iterations_run expected %0d actual %0d", f.iters, rsp_iterations_run);
               failures++;
            end
            if (rsp_converged !== f.conv) begin
               $error("converged expected %0d actual %0d", f.conv, rsp_converged);
               failures++;
            end
            if (rsp_status !== f.status) begin
               $error("status expected %0d actual %0d", f.status, rsp_status);
               failures++;
            end
         end
      end
   end

endmodule

FILE: files.f
design/lrgd_pkg.sv
design/lrgd_divider.sv
design/lrgd_datapath.sv
design/lrgd_controller.sv
design/linear_regression_gradient_descent_top.sv
design/lrgd_checker.sv
tb/linear_regression_gradient_descent_top_tb.sv
